// ===== hw/rtl/ps2s1_pkg.sv =====
package ps2s1_pkg;

    // Map sizing
    localparam int KEY_SLOTS_DEF = 128;

    // Field widths
    localparam int BYTE_W = 8;
    localparam int KC_W   = 7;
    localparam int LED_W  = 3;
    localparam int DISC_W = 3;

    // Special bytes of scan code set 1
    localparam logic [BYTE_W-1:0] PREFIX_BYTE = 8'he0;
    localparam logic [BYTE_W-1:0] PAUSE_BYTE  = 8'he1;
    localparam logic [BYTE_W-1:0] PRTSC_MAKE  = 8'h2a;
    localparam logic [BYTE_W-1:0] PRTSC_BREAK = 8'hb7;
    localparam int                BREAK_BIT   = 7;

    // Extended table slots used by the multi-byte sequences
    localparam logic [KC_W-1:0] EXT_PRTSC_IDX = 7'h6e;
    localparam logic [KC_W-1:0] EXT_PAUSE_IDX = 7'h6f;

    // Bytes swallowed after the multi-byte sequences
    localparam logic [DISC_W-1:0] PAUSE_DISCARD = 3'd5;
    localparam logic [DISC_W-1:0] PRTSC_DISCARD = 3'd2;

    // Key codes with side effects
    localparam logic [KC_W-1:0] KC_CAPS   = 7'h30;
    localparam logic [KC_W-1:0] KC_LSHIFT = 7'h40;
    localparam logic [KC_W-1:0] KC_RSHIFT = 7'h4b;
    localparam logic [KC_W-1:0] KC_SCROLL = 7'h61;
    localparam logic [KC_W-1:0] KC_PAUSE  = 7'h62;

    // LED bit positions
    localparam int LED_SCROLL = 0;
    localparam int LED_CAPS   = 2;

    // Table lengths
    localparam int PLAIN_LEN = 89;
    localparam int EXT_LEN   = 112;

    localparam logic [KC_W-1:0] PLAIN_TAB [PLAIN_LEN] = '{
        7'h00, 7'h00,
        7'h11, 7'h12, 7'h13, 7'h14, 7'h15, 7'h16, 7'h17, 7'h18, 7'h19, 7'h1a, 7'h1b,
        7'h1c, 7'h1d,
        7'h20, 7'h21, 7'h22, 7'h23, 7'h24, 7'h25, 7'h26, 7'h27, 7'h28, 7'h29, 7'h2a,
        7'h2b, 7'h2c,
        7'h3c, 7'h50,
        7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h3a, 7'h3b,
        7'h10, 7'h40, 7'h2d,
        7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46, 7'h47, 7'h48, 7'h49, 7'h4a, 7'h4b,
        7'h00, 7'h52, 7'h53, 7'h30,
        7'h01, 7'h02, 7'h03, 7'h04, 7'h05, 7'h06, 7'h07, 7'h08, 7'h09, 7'h0a,
        7'h00, 7'h61,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00,
        7'h00, 7'h00, 7'h00,
        7'h0b, 7'h0c
    };

    // Extended table: sparse, so written as a case; slots past the end give 0
    function automatic logic [KC_W-1:0] ext_code(input logic [KC_W-1:0] idx);
        logic [KC_W-1:0] kc;
        kc = '0;
        case (idx)
            7'h1d:   kc = 7'h57;
            7'h38:   kc = 7'h54;
            7'h47:   kc = 7'h64;
            7'h48:   kc = 7'h70;
            7'h49:   kc = 7'h65;
            7'h4b:   kc = 7'h71;
            7'h4d:   kc = 7'h73;
            7'h4f:   kc = 7'h67;
            7'h50:   kc = 7'h72;
            7'h51:   kc = 7'h68;
            7'h52:   kc = 7'h63;
            7'h53:   kc = 7'h66;
            7'h5b:   kc = 7'h51;
            7'h5c:   kc = 7'h55;
            7'h5d:   kc = 7'h56;
            7'h6e:   kc = 7'h60;
            7'h6f:   kc = 7'h62;
            default: kc = '0;
        endcase
        return kc;
    endfunction

endpackage

// ===== hw/rtl/ps2s1_keymap.sv =====
module ps2s1_keymap
(
    input  logic [ps2s1_pkg::KC_W-1:0] idx,
    input  logic                       ext,
    output logic [ps2s1_pkg::KC_W-1:0] key_code
);

    // Look up the plain or the extended table; out of range gives code 0
    always_comb
    begin
        if (ext)
        begin
            key_code = ps2s1_pkg::ext_code(idx);
        end
        else if (int'(idx) < ps2s1_pkg::PLAIN_LEN)
        begin
            key_code = ps2s1_pkg::PLAIN_TAB[idx];
        end
        else
        begin
            key_code = '0;
        end
    end

endmodule

// ===== hw/rtl/ps2_set1_scancode_decoder_core.sv =====
// An accepted scan byte is held in the input register; decode and state update then
//   write its result into the result register; input refills while a result waits.
// Throughput: one byte per cycle while out_ready takes the results.
// The decode state and the pressed-key map update once per byte, in the decode cycle.
// Reset (rst_n low, asynchronous) clears the prefix flag, the discard count, both lock
//   toggles, the whole pressed-key map and both valid flags.
module ps2_set1_scancode_decoder_core
#(
    parameter int KEY_SLOTS = ps2s1_pkg::KEY_SLOTS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [ps2s1_pkg::BYTE_W-1:0] scan_byte,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         event_valid,
    output logic [ps2s1_pkg::KC_W-1:0]   key_code,
    output logic                         key_released,
    output logic                         shift_held,
    output logic                         caps_state,
    output logic                         scroll_state,
    output logic                         led_update,
    output logic [ps2s1_pkg::LED_W-1:0]  led_bits
);

    localparam int MAP_IDX_W = $clog2(KEY_SLOTS);

    // Input stage
    logic                         s1_valid_reg;
    logic [ps2s1_pkg::BYTE_W-1:0] s1_byte_reg;

    // Decode state
    logic                         prefix_reg;
    logic                         prefix_next;
    logic [ps2s1_pkg::DISC_W-1:0] discard_reg;
    logic [ps2s1_pkg::DISC_W-1:0] discard_next;
    logic                         caps_reg;
    logic                         caps_next;
    logic                         scroll_reg;
    logic                         scroll_next;
    logic [KEY_SLOTS-1:0]         map_reg;

    // Result register
    logic                         out_valid_reg;
    logic                         ev_reg;
    logic [ps2s1_pkg::KC_W-1:0]   kc_reg;
    logic                         rel_reg;
    logic                         shift_reg;
    logic                         led_reg;

    // Decode results
    logic                         ev_next;
    logic [ps2s1_pkg::KC_W-1:0]   kc_next;
    logic                         rel_next;
    logic                         led_next;
    logic                         shift_next;
    logic                         map_we;
    logic [ps2s1_pkg::KC_W-1:0]   map_kc;
    logic                         map_val;
    logic [MAP_IDX_W-1:0]         map_idx;
    logic [MAP_IDX_W-1:0]         lshift_idx;
    logic [MAP_IDX_W-1:0]         rshift_idx;
    logic                         lshift_now;
    logic                         rshift_now;

    logic [ps2s1_pkg::KC_W-1:0]   lut_kc;
    logic                         byte_rel;

    logic                         out_adv;
    logic                         s1_fire;

    // Handshake
    assign out_adv  = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && out_adv;
    assign in_ready = !s1_valid_reg || out_adv;

    // Table lookup on the low seven bits
    assign byte_rel = s1_byte_reg[ps2s1_pkg::BREAK_BIT];

    ps2s1_keymap u_keymap
    (
        .idx      (s1_byte_reg[ps2s1_pkg::KC_W-1:0]),
        .ext      (prefix_reg),
        .key_code (lut_kc)
    );

    // Decode one byte against the current state
    always_comb
    begin
        prefix_next  = prefix_reg;
        discard_next = discard_reg;
        caps_next    = caps_reg;
        scroll_next  = scroll_reg;
        ev_next      = 1'b0;
        kc_next      = '0;
        rel_next     = 1'b0;
        led_next     = 1'b0;
        map_we       = 1'b0;
        map_kc       = '0;
        map_val      = 1'b0;

        if (discard_reg != '0)
        begin
            discard_next = discard_reg - 1'b1;
        end
        else if (s1_byte_reg == ps2s1_pkg::PREFIX_BYTE)
        begin
            prefix_next = 1'b1;
        end
        else if (s1_byte_reg == ps2s1_pkg::PAUSE_BYTE)
        begin
            discard_next = ps2s1_pkg::PAUSE_DISCARD;
            prefix_next  = 1'b0;
            ev_next      = 1'b1;
            kc_next      = ps2s1_pkg::ext_code(ps2s1_pkg::EXT_PAUSE_IDX);
        end
        else if (prefix_reg && (s1_byte_reg == ps2s1_pkg::PRTSC_MAKE ||
                                s1_byte_reg == ps2s1_pkg::PRTSC_BREAK))
        begin
            rel_next     = (s1_byte_reg == ps2s1_pkg::PRTSC_BREAK);
            kc_next      = ps2s1_pkg::ext_code(ps2s1_pkg::EXT_PRTSC_IDX);
            map_we       = 1'b1;
            map_kc       = kc_next;
            map_val      = !rel_next;
            discard_next = ps2s1_pkg::PRTSC_DISCARD;
            prefix_next  = 1'b0;
            ev_next      = 1'b1;
        end
        else
        begin
            rel_next    = byte_rel;
            kc_next     = lut_kc;
            map_we      = (lut_kc != ps2s1_pkg::KC_PAUSE);
            map_kc      = lut_kc;
            map_val     = !byte_rel;
            prefix_next = 1'b0;
            ev_next     = 1'b1;
            if (lut_kc == ps2s1_pkg::KC_CAPS && !byte_rel)
            begin
                caps_next = !caps_reg;
                led_next  = 1'b1;
            end
            if (lut_kc == ps2s1_pkg::KC_SCROLL && !byte_rel)
            begin
                scroll_next = !scroll_reg;
                led_next    = 1'b1;
            end
        end
    end

    // Shift state after this byte's map write
    assign map_idx    = MAP_IDX_W'(map_kc);
    assign lshift_idx = MAP_IDX_W'(ps2s1_pkg::KC_LSHIFT);
    assign rshift_idx = MAP_IDX_W'(ps2s1_pkg::KC_RSHIFT);
    assign lshift_now = (map_we && map_idx == lshift_idx) ? map_val : map_reg[lshift_idx];
    assign rshift_now = (map_we && map_idx == rshift_idx) ? map_val : map_reg[rshift_idx];
    assign shift_next = lshift_now | rshift_now;

    // Hold the accepted byte until decode takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_byte_reg <= scan_byte;
        end
    end

    // Advance decode state and the pressed-key map
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg  <= 1'b0;
            discard_reg <= '0;
            caps_reg    <= 1'b0;
            scroll_reg  <= 1'b0;
            map_reg     <= '0;
        end
        else if (s1_fire)
        begin
            prefix_reg  <= prefix_next;
            discard_reg <= discard_next;
            caps_reg    <= caps_next;
            scroll_reg  <= scroll_next;
            if (map_we)
            begin
                map_reg[map_idx] <= map_val;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            ev_reg    <= ev_next;
            kc_reg    <= kc_next;
            rel_reg   <= rel_next;
            shift_reg <= shift_next;
            led_reg   <= led_next;
        end
    end

    // Drive outputs; lock states come straight from the state registers
    assign out_valid    = out_valid_reg;
    assign event_valid  = ev_reg;
    assign key_code     = kc_reg;
    assign key_released = rel_reg;
    assign shift_held   = shift_reg;
    assign caps_state   = caps_reg;
    assign scroll_state = scroll_reg;
    assign led_update   = led_reg;

    always_comb
    begin
        led_bits                       = '0;
        led_bits[ps2s1_pkg::LED_SCROLL] = scroll_reg;
        led_bits[ps2s1_pkg::LED_CAPS]   = caps_reg;
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        logic                         evt;
        logic [ps2s1_pkg::KC_W-1:0]   code;
        logic                         rel;
        logic                         shift;
        logic                         caps;
        logic                         scroll;
        logic                         led_upd;
        logic [ps2s1_pkg::LED_W-1:0]  leds;
    } key_result_t;

    typedef struct packed {
        logic [ps2s1_pkg::BYTE_W-1:0] b;
        logic                         has_exp;
        key_result_t                  want;
    } dir_row_t;

    localparam logic [ps2s1_pkg::KC_W-1:0] KC_PRTSC = 7'h60;

    // Make codes of the keys with side effects
    localparam logic [ps2s1_pkg::BYTE_W-1:0] SC_LSHIFT = 8'h2a;
    localparam logic [ps2s1_pkg::BYTE_W-1:0] SC_RSHIFT = 8'h36;
    localparam logic [ps2s1_pkg::BYTE_W-1:0] SC_CAPS   = 8'h3a;
    localparam logic [ps2s1_pkg::BYTE_W-1:0] SC_SCROLL = 8'h46;

    localparam int TOTAL_BYTES = 1650;
    localparam int LONG_HOLD   = 200;

    localparam int PLAIN_N = 89;
    localparam logic [ps2s1_pkg::KC_W-1:0] PLAIN_KC [PLAIN_N] = '{
        7'h00, 7'h00,
        7'h11, 7'h12, 7'h13, 7'h14, 7'h15, 7'h16, 7'h17, 7'h18, 7'h19, 7'h1a, 7'h1b,
        7'h1c, 7'h1d,
        7'h20, 7'h21, 7'h22, 7'h23, 7'h24, 7'h25, 7'h26, 7'h27, 7'h28, 7'h29, 7'h2a,
        7'h2b, 7'h2c,
        7'h3c, 7'h50,
        7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h3a, 7'h3b,
        7'h10, 7'h40, 7'h2d,
        7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46, 7'h47, 7'h48, 7'h49, 7'h4a, 7'h4b,
        7'h00, 7'h52, 7'h53, 7'h30,
        7'h01, 7'h02, 7'h03, 7'h04, 7'h05, 7'h06, 7'h07, 7'h08, 7'h09, 7'h0a,
        7'h00, 7'h61,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h0b, 7'h0c
    };

    // Extended table is sparse: slot and key code pairs, everything else is 0
    localparam int EXT_N = 17;
    localparam logic [ps2s1_pkg::KC_W-1:0] EXT_SLOT [EXT_N] = '{
        7'h1d, 7'h38, 7'h47, 7'h48, 7'h49, 7'h4b, 7'h4d, 7'h4f, 7'h50,
        7'h51, 7'h52, 7'h53, 7'h5b, 7'h5c, 7'h5d, 7'h6e, 7'h6f
    };
    localparam logic [ps2s1_pkg::KC_W-1:0] EXT_KC [EXT_N] = '{
        7'h57, 7'h54, 7'h64, 7'h70, 7'h65, 7'h71, 7'h73, 7'h67, 7'h72,
        7'h68, 7'h63, 7'h66, 7'h51, 7'h55, 7'h56, 7'h60, 7'h62
    };

    // Directed bytes; fields: evt code rel shift caps scroll led_upd leds
    localparam int DIR_N = 29;
    localparam dir_row_t DIR_TAB [DIR_N] = '{
        '{8'h00, 1'b1, '{1'b1, 7'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 3'b000}},
        '{8'hff, 1'b1, '{1'b1, 7'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 3'b000}},
        '{8'h3a, 1'b1, '{1'b1, 7'h30, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 3'b100}},
        '{8'h3a, 1'b1, '{1'b1, 7'h30, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 3'b000}},
        '{8'hba, 1'b0, '0},
        '{8'h46, 1'b1, '{1'b1, 7'h61, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 3'b001}},
        '{8'h2a, 1'b0, '0},
        '{8'h36, 1'b0, '0},
        '{8'he0, 1'b0, '0},
        '{8'he0, 1'b0, '0},
        '{8'h2a, 1'b0, '0},
        '{8'he0, 1'b0, '0},
        '{8'he1, 1'b0, '0},
        '{8'he0, 1'b0, '0},
        '{8'hb7, 1'b0, '0},
        '{8'he0, 1'b0, '0},
        '{8'haa, 1'b0, '0},
        '{8'he1, 1'b0, '0},
        '{8'h1d, 1'b0, '0},
        '{8'h45, 1'b0, '0},
        '{8'he1, 1'b0, '0},
        '{8'h9d, 1'b0, '0},
        '{8'hc5, 1'b0, '0},
        '{8'he0, 1'b0, '0},
        '{8'h6f, 1'b0, '0},
        '{8'he0, 1'b0, '0},
        '{8'hff, 1'b0, '0},
        '{8'h59, 1'b0, '0},
        '{8'hb6, 1'b0, '0}
    };

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    logic [ps2s1_pkg::BYTE_W-1:0]   scan_byte;
    logic                           out_valid;
    logic                           out_ready;
    logic                           event_valid;
    logic [ps2s1_pkg::KC_W-1:0]     key_code;
    logic                           key_released;
    logic                           shift_held;
    logic                           caps_state;
    logic                           scroll_state;
    logic                           led_update;
    logic [ps2s1_pkg::LED_W-1:0]    led_bits;

    // Decoder state mirror
    logic                           ext_armed;
    logic [ps2s1_pkg::DISC_W-1:0]   swallow_cnt;
    logic                           caps_on;
    logic                           scroll_on;
    logic [127:0]                   held_keys;

    key_result_t decoded_q [$];
    int unsigned bytes_sent;
    int unsigned fail_count;
    logic        idle_on;
    logic        long_hold_req;

    ps2_set1_scancode_decoder_core u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .scan_byte    (scan_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_valid  (event_valid),
        .key_code     (key_code),
        .key_released (key_released),
        .shift_held   (shift_held),
        .caps_state   (caps_state),
        .scroll_state (scroll_state),
        .led_update   (led_update),
        .led_bits     (led_bits)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic logic [ps2s1_pkg::KC_W-1:0] ext_lookup(
        input logic [ps2s1_pkg::KC_W-1:0] idx);
        logic [ps2s1_pkg::KC_W-1:0] kc;
        kc = '0;
        for (int i = 0; i < EXT_N; i++)
        begin
            if (EXT_SLOT[i] == idx)
                kc = EXT_KC[i];
        end
        return kc;
    endfunction

    // Advance the mirrored state by one byte and return the result it yields
    function automatic key_result_t decode_scan(input logic [ps2s1_pkg::BYTE_W-1:0] b);
        key_result_t r;
        logic [ps2s1_pkg::KC_W-1:0] kc;
        r = '0;
        if (swallow_cnt != 0)
        begin
            swallow_cnt = swallow_cnt - 1'b1;
        end
        else if (b == ps2s1_pkg::PREFIX_BYTE)
        begin
            ext_armed = 1'b1;
        end
        else if (b == ps2s1_pkg::PAUSE_BYTE)
        begin
            swallow_cnt = ps2s1_pkg::PAUSE_DISCARD;
            ext_armed   = 1'b0;
            r.evt       = 1'b1;
            r.code      = ext_lookup(ps2s1_pkg::EXT_PAUSE_IDX);
        end
        else if (ext_armed && (b == ps2s1_pkg::PRTSC_MAKE || b == ps2s1_pkg::PRTSC_BREAK))
        begin
            r.rel               = (b == ps2s1_pkg::PRTSC_BREAK);
            held_keys[KC_PRTSC] = ~r.rel;
            swallow_cnt         = ps2s1_pkg::PRTSC_DISCARD;
            ext_armed           = 1'b0;
            r.evt               = 1'b1;
            r.code              = ext_lookup(ps2s1_pkg::EXT_PRTSC_IDX);
        end
        else
        begin
            r.rel = b[ps2s1_pkg::BREAK_BIT];
            if (ext_armed)
                kc = ext_lookup(b[ps2s1_pkg::KC_W-1:0]);
            else
                kc = (b[ps2s1_pkg::KC_W-1:0] < PLAIN_N) ?
                     PLAIN_KC[b[ps2s1_pkg::KC_W-1:0]] : '0;
            if (kc != ps2s1_pkg::KC_PAUSE)
                held_keys[kc] = ~r.rel;
            if (kc == ps2s1_pkg::KC_CAPS && !r.rel)
            begin
                caps_on   = ~caps_on;
                r.led_upd = 1'b1;
            end
            if (kc == ps2s1_pkg::KC_SCROLL && !r.rel)
            begin
                scroll_on = ~scroll_on;
                r.led_upd = 1'b1;
            end
            ext_armed = 1'b0;
            r.evt     = 1'b1;
            r.code    = kc;
        end
        r.shift  = held_keys[ps2s1_pkg::KC_LSHIFT] | held_keys[ps2s1_pkg::KC_RSHIFT];
        r.caps   = caps_on;
        r.scroll = scroll_on;
        r.leds   = '0;
        r.leds[ps2s1_pkg::LED_SCROLL] = scroll_on;
        r.leds[ps2s1_pkg::LED_CAPS]   = caps_on;
        return r;
    endfunction

    // Mostly no gap, sometimes a short one, rarely a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Offer one byte; record its expected result once the transaction completes
    task automatic drive_byte(input logic [ps2s1_pkg::BYTE_W-1:0] b, input logic has_exp,
                              input key_result_t want);
        int unsigned gap;
        key_result_t pred;
        gap = idle_on ? pick_gap() : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        scan_byte <= b;
        do @(posedge clk); while (!in_ready);
        pred = decode_scan(b);
        decoded_q.push_back(has_exp ? want : pred);
        bytes_sent++;
    endtask

    task automatic send(input logic [ps2s1_pkg::BYTE_W-1:0] b);
        drive_byte(b, 1'b0, '0);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (decoded_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            fail_count++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    // Receiver: random back-pressure, plus one long hold on request
    initial
    begin
        out_ready = 1'b0;
        begin : recv
            int unsigned hold_left;
            hold_left = 0;
            @(posedge rst_n);
            forever
            begin
                @(negedge clk);
                if (long_hold_req)
                begin
                    out_ready <= 1'b0;
                    repeat (LONG_HOLD) @(negedge clk);
                    long_hold_req = 1'b0;
                    out_ready <= 1'b1;
                end
                else if (hold_left != 0)
                begin
                    out_ready <= 1'b0;
                    hold_left--;
                end
                else
                begin
                    out_ready <= 1'b1;
                    if (idle_on)
                        hold_left = pick_gap();
                end
            end
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        key_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (decoded_q.size() == 0)
            begin
                fail_count++;
                $display("%0t: result with nothing expected, key_code %0h",
                         $time, key_code);
            end
            else
            begin
                want = decoded_q.pop_front();
                check_field("event_valid", want.evt, event_valid);
                check_field("key_code", want.code, key_code);
                check_field("key_released", want.rel, key_released);
                check_field("shift_held", want.shift, shift_held);
                check_field("caps_state", want.caps, caps_state);
                check_field("scroll_state", want.scroll, scroll_state);
                check_field("led_update", want.led_upd, led_update);
                check_field("led_bits", want.leds, led_bits);
            end
        end
    end

    initial
    begin
        #(64'd20_000_000);
        $display("ps2_set1_scancode_decoder_core: mismatch");
        $finish;
    end

    initial
    begin
        int unsigned pick;
        int unsigned n;
        logic        hold_done;
        logic        drain_done;
        logic [ps2s1_pkg::KC_W-1:0] idx;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        scan_byte     = '0;
        idle_on       = 1'b1;
        long_hold_req = 1'b0;
        bytes_sent    = 0;
        fail_count    = 0;
        hold_done     = 1'b0;
        drain_done    = 1'b0;
        ext_armed     = 1'b0;
        swallow_cnt   = '0;
        caps_on       = 1'b0;
        scroll_on     = 1'b0;
        held_keys     = '0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed bytes: extremes, locks, shifts, prefixes and the long sequences
        for (int i = 0; i < DIR_N; i++)
            drive_byte(DIR_TAB[i].b, DIR_TAB[i].has_exp, DIR_TAB[i].want);
        wait_drained();

        // Random traffic, mostly well-formed key sequences
        while (bytes_sent < TOTAL_BYTES)
        begin
            idle_on = ((bytes_sent / 150) % 4) != 2;
            if (!hold_done && bytes_sent >= 500)
            begin
                hold_done     = 1'b1;
                long_hold_req = 1'b1;
            end
            if (!drain_done && bytes_sent >= 1100)
            begin
                drain_done = 1'b1;
                wait_drained();
            end
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                // plain make or break, biased toward shift and lock keys
                if ($urandom_range(0, 99) < 20)
                begin
                    case ($urandom_range(0, 3))
                        0:       idx = SC_LSHIFT[ps2s1_pkg::KC_W-1:0];
                        1:       idx = SC_RSHIFT[ps2s1_pkg::KC_W-1:0];
                        2:       idx = SC_CAPS[ps2s1_pkg::KC_W-1:0];
                        default: idx = SC_SCROLL[ps2s1_pkg::KC_W-1:0];
                    endcase
                end
                else
                begin
                    idx = ps2s1_pkg::KC_W'($urandom_range(0, PLAIN_N - 1));
                end
                send({1'($urandom_range(0, 1)), idx});
            end
            else if (pick < 65)
            begin
                // extended key, usually a real one
                if ($urandom_range(0, 3) != 0)
                    idx = EXT_SLOT[$urandom_range(0, EXT_N - 1)];
                else
                    idx = ps2s1_pkg::KC_W'($urandom_range(0, 127));
                send(ps2s1_pkg::PREFIX_BYTE);
                send({1'($urandom_range(0, 1)), idx});
            end
            else if (pick < 72)
            begin
                // print screen press or release, four bytes
                send(ps2s1_pkg::PREFIX_BYTE);
                if ($urandom_range(0, 1) != 0)
                begin
                    send(ps2s1_pkg::PRTSC_MAKE);
                    send(ps2s1_pkg::PREFIX_BYTE);
                    send(8'h37);
                end
                else
                begin
                    send(ps2s1_pkg::PRTSC_BREAK);
                    send(ps2s1_pkg::PREFIX_BYTE);
                    send(8'haa);
                end
            end
            else if (pick < 77)
            begin
                // pause, six bytes
                send(ps2s1_pkg::PAUSE_BYTE);
                send(8'h1d);
                send(8'h45);
                send(ps2s1_pkg::PAUSE_BYTE);
                send(8'h9d);
                send(8'hc5);
            end
            else if (pick < 92)
            begin
                send(ps2s1_pkg::BYTE_W'($urandom_range(0, 255)));
            end
            else
            begin
                // broken sequences: cut short or with random tails
                send($urandom_range(0, 1) != 0 ? ps2s1_pkg::PREFIX_BYTE
                                               : ps2s1_pkg::PAUSE_BYTE);
                n = $urandom_range(0, 6);
                repeat (n) send(ps2s1_pkg::BYTE_W'($urandom_range(0, 255)));
            end
        end

        // Drain, then let the pipeline settle
        wait_drained();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("ps2_set1_scancode_decoder_core: match");
        else
            $display("ps2_set1_scancode_decoder_core: mismatch");
        $finish;
    end

endmodule
